/* hdl/sha1md_pkg.sv */
// shared types and constants for the sha-1 message digest block
// no dependencies; imported by every module under hdl/
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BLOCK_W     = 512;
  localparam int unsigned FILL_W      = 6;
  localparam int unsigned ROUND_W     = 7;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned LEN_FIELD_W = 64;
  localparam int unsigned NUM_WORDS   = 5;

  localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
  localparam logic [FILL_W-1:0]  PAD_STOP   = 6'd56;
  localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
  localparam logic [IDX_W-1:0]   IDX_LAST   = 3'd4;
  localparam logic [BYTE_W-1:0]  PAD_MARK   = 8'h80;

  localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

  localparam logic [NUM_WORDS-1:0][WORD_W-1:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha1md_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1md_out_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
  } sha1md_work_t;

  typedef struct packed {
    logic              shift_byte;
    logic              step;
    logic [BYTE_W-1:0] byte_val;
  } sha1md_sched_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } sha1md_state_t;

endpackage

`default_nettype wire

/* hdl/sha1md_top.sv */
// sha-1 digest top: sequencer (fill, pad, compress, emit), chaining words
// depends on sha1md_pkg, sha1md_sched, sha1md_round
// timing: a beat that fills the block drops in_ready while the block is compressed
// (80 rounds and a fold); after the end beat the block is padded, given its length and compressed
// before the first digest word is valid; throughput: one beat a cycle while filling, no input
// during pad, compress or digest output; reset: rst_n sync active low, idle with initial hash
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest_top #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  sha1md_pkg::sha1md_in_t     in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output sha1md_pkg::sha1md_out_t    out_data
);
  import sha1md_pkg::*;

  sha1md_state_t         state_r, state_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [LENGTH_BITS-1:0] bitcnt_r, bitcnt_nxt;
  logic [LEN_FIELD_W-1:0] len_r, len_nxt;
  logic                   mark_r, mark_nxt;
  logic                   end_r, end_nxt;
  logic                   fin_r, fin_nxt;
  logic [ROUND_W-1:0]     rnd_r, rnd_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [NUM_WORDS-1:0][WORD_W-1:0] h_r, h_nxt;
  sha1md_work_t           work_r, work_nxt, work_rnd;
  sha1md_sched_ctl_t      sched_ctl;
  logic [WORD_W-1:0]      w_cur;
  logic                   in_fire;
  logic                   out_fire;
  logic                   out_done;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;
  assign out_done = out_fire & (idx_r == IDX_LAST);

  sha1md_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_out (w_cur)
  );

  sha1md_round u_round (
    .work_in  (work_r),
    .w_in     (w_cur),
    .rnd      (rnd_r),
    .work_out (work_rnd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.has_byte && fill_r == FILL_LAST) begin
            state_nxt = ST_ROUND;
          end else if (in_data.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == PAD_STOP && !mark_r) begin
          state_nxt = ST_LEN;
        end else if (fill_r == FILL_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_LEN: begin
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (fin_r) begin
          state_nxt = ST_OUT;
        end else if (end_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and buffer control
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    sched_ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready             = 1'b1;
        sched_ctl.shift_byte = in_fire & in_data.has_byte;
        sched_ctl.byte_val   = in_data.data_byte;
      end
      ST_PAD: begin
        sched_ctl.shift_byte = ~(fill_r == PAD_STOP && !mark_r);
        sched_ctl.byte_val   = mark_r ? PAD_MARK : '0;
      end
      ST_LEN: begin
        sched_ctl.shift_byte = 1'b1;
        sched_ctl.byte_val   = len_r[LEN_FIELD_W-1 -: BYTE_W];
      end
      ST_ROUND: begin
        sched_ctl.step = 1'b1;
      end
      ST_FOLD: begin
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_data.digest_word = h_r[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == IDX_LAST);

  // datapath next values
  always_comb begin
    fill_nxt   = fill_r;
    bitcnt_nxt = bitcnt_r;
    len_nxt    = len_r;
    mark_nxt   = mark_r;
    end_nxt    = end_r;
    fin_nxt    = fin_r;
    rnd_nxt    = '0;
    idx_nxt    = idx_r;
    h_nxt      = h_r;
    work_nxt   = work_r;

    // every byte pushed into the buffer advances the fill count
    if (sched_ctl.shift_byte) begin
      fill_nxt = fill_r + 1'b1;
    end

    if (in_fire) begin
      if (in_data.has_byte) begin
        bitcnt_nxt = bitcnt_r + LENGTH_BITS'(8);
      end
      if (in_data.last) begin
        mark_nxt = 1'b1;
        end_nxt  = 1'b1;
      end
    end

    if (state_r == ST_PAD) begin
      if (mark_r) begin
        mark_nxt = 1'b0;
      end
      if (state_nxt == ST_LEN) begin
        // length field is always 64 bits, high bits zero below full width
        len_nxt = LEN_FIELD_W'(bitcnt_r);
      end
    end

    if (state_r == ST_LEN) begin
      len_nxt = {len_r[LEN_FIELD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
      if (state_nxt == ST_ROUND) begin
        fin_nxt = 1'b1;
      end
    end

    if (state_r == ST_ROUND) begin
      rnd_nxt  = rnd_r + 1'b1;
      work_nxt = work_rnd;
    end else if (state_nxt == ST_ROUND) begin
      work_nxt = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
    end

    if (state_r == ST_FOLD) begin
      h_nxt[0] = h_r[0] + work_r.a;
      h_nxt[1] = h_r[1] + work_r.b;
      h_nxt[2] = h_r[2] + work_r.c;
      h_nxt[3] = h_r[3] + work_r.d;
      h_nxt[4] = h_r[4] + work_r.e;
    end

    if (out_fire) begin
      idx_nxt = idx_r + 1'b1;
    end

    // last digest beat taken: reinitialize for the next message
    if (out_done) begin
      idx_nxt    = '0;
      h_nxt      = H_INIT;
      bitcnt_nxt = '0;
      end_nxt    = 1'b0;
      fin_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      bitcnt_r <= '0;
      mark_r   <= 1'b0;
      end_r    <= 1'b0;
      fin_r    <= 1'b0;
      rnd_r    <= '0;
      idx_r    <= '0;
      h_r      <= H_INIT;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bitcnt_r <= bitcnt_nxt;
      mark_r   <= mark_nxt;
      end_r    <= end_nxt;
      fin_r    <= fin_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      h_r      <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    work_r <= work_nxt;
  end

endmodule

`default_nettype wire

/* hdl/sha1md_sched.sv */
// block buffer and message schedule: a 512-bit shift line of bytes that
// later slides word by word to form w[t]; depends on sha1md_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha1md_sched (
  input  wire                                   clk,
  input  sha1md_pkg::sha1md_sched_ctl_t         ctl,
  output logic [sha1md_pkg::WORD_W-1:0]         w_out
);
  import sha1md_pkg::*;

  logic [BLOCK_W-1:0] win_r;
  logic [BLOCK_W-1:0] win_nxt;
  logic [WORD_W-1:0]  mix;
  logic [WORD_W-1:0]  w_new;

  // word j of the window sits at bits [511-32j -: 32]
  assign mix   = win_r[511-32*13 -: 32] ^ win_r[511-32*8 -: 32] ^
                 win_r[511-32*2 -: 32] ^ win_r[511 -: 32];
  assign w_new = {mix[WORD_W-2:0], mix[WORD_W-1]};
  assign w_out = win_r[511 -: 32];

  always_comb begin
    win_nxt = win_r;
    if (ctl.shift_byte) begin
      win_nxt = {win_r[BLOCK_W-BYTE_W-1:0], ctl.byte_val};
    end else if (ctl.step) begin
      win_nxt = {win_r[BLOCK_W-WORD_W-1:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

/* hdl/sha1md_round.sv */
// one sha-1 round, shared across all 80 rounds of a block
// depends on sha1md_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha1md_round (
  input  sha1md_pkg::sha1md_work_t               work_in,
  input  wire [sha1md_pkg::WORD_W-1:0]           w_in,
  input  wire [sha1md_pkg::ROUND_W-1:0]          rnd,
  output sha1md_pkg::sha1md_work_t               work_out
);
  import sha1md_pkg::*;

  logic [WORD_W-1:0] f;
  logic [WORD_W-1:0] k;
  logic [WORD_W-1:0] t;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
      k = K_0;
    end else if (rnd < 7'd40) begin
      f = work_in.b ^ work_in.c ^ work_in.d;
      k = K_1;
    end else if (rnd < 7'd60) begin
      f = (work_in.b & work_in.c) | (work_in.b & work_in.d) | (work_in.c & work_in.d);
      k = K_2;
    end else begin
      f = work_in.b ^ work_in.c ^ work_in.d;
      k = K_3;
    end
    t = {work_in.a[26:0], work_in.a[31:27]} + f + work_in.e + k + w_in;
    work_out.a = t;
    work_out.b = work_in.a;
    work_out.c = {work_in.b[1:0], work_in.b[31:2]};
    work_out.d = work_in.c;
    work_out.e = work_in.d;
  end

endmodule

`default_nettype wire
